// ----- rtl/header_length_command_frame_parser_core_macros.svh -----
// assertion macros shared by the checker
`ifndef HEADER_LENGTH_COMMAND_FRAME_PARSER_CORE_MACROS_SVH
`define HEADER_LENGTH_COMMAND_FRAME_PARSER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HLCFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hlcfp assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define HLCFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hlcfp assertion failed");

`endif

// ----- rtl/hlcfp_pkg.sv -----
package hlcfp_pkg;

    typedef enum logic [2:0] {
        ST_HEADER1 = 3'd0,
        ST_HEADER2 = 3'd1,
        ST_LENGTH  = 3'd2,
        ST_COMMAND = 3'd3,
        ST_PAYLOAD = 3'd4
    } parse_state_t;

    typedef enum logic [0:0] {
        CFG_HEADER_BYTE   = 1'b0,
        CFG_COMMAND_LIMIT = 1'b1
    } cfg_index_t;

    localparam logic [7:0] HEADER_BYTE_RESET   = 8'd85;
    localparam logic [7:0] COMMAND_LIMIT_RESET = 8'd32;
    localparam logic [7:0] SHORT_FRAME_LENGTH  = 8'd2;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] command_limit;
    } cfg_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       frame_done;
        logic [7:0] command;
        logic [7:0] data_length;
    } result_t;

endpackage

// ----- rtl/header_length_command_frame_parser_core.sv -----
// a transferred byte waits in the input register, then its result is registered in
// the output register; throughput: one byte per cycle while result_stall is low;
// the input register refills while the result drains
// the single frame-state update between input and result register sets that pace
// reset (rst_n low, asynchronous): parser hunts for the first header, counters zero,
// header_byte = 85, command_limit = 32, both pipeline stages empty
module header_length_command_frame_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    // received bytes
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  rx_byte,
    // one result per received byte
    output logic        result_valid,
    input  logic        result_stall,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic [7:0]  payload_index,
    output logic        frame_done,
    output logic [7:0]  command,
    output logic [7:0]  data_length,
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    hlcfp_pkg::cfg_t    cfg;
    hlcfp_pkg::result_t step_result;

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    hlcfp_pkg::result_t out_data_reg;

    logic advance;
    logic step;
    logic in_take;

    // result register can load when empty or when its transfer completes now
    assign advance    = !out_valid_reg || !result_stall;
    // the byte in the input register moves through the parser into the result register
    assign step       = in_valid_reg && advance;
    // input register is free when empty or emptying this cycle
    assign byte_stall = in_valid_reg && !advance;
    assign in_take    = byte_valid && !byte_stall;

    hlcfp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (hlcfp_pkg::cfg_index_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // frame state machine; state advances only when a byte steps through
    hlcfp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!byte_stall)
        begin
            in_valid_next = byte_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step)
        begin
            out_data_reg <= step_result;
        end
    end

    assign result_valid  = out_valid_reg;
    assign payload_valid = out_data_reg.payload_valid;
    assign payload_byte  = out_data_reg.payload_byte;
    assign payload_index = out_data_reg.payload_index;
    assign frame_done    = out_data_reg.frame_done;
    assign command       = out_data_reg.command;
    assign data_length   = out_data_reg.data_length;

endmodule

// ----- rtl/hlcfp_cfg_regs.sv -----
module hlcfp_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  hlcfp_pkg::cfg_index_t     cfg_index,
    input  logic [7:0]                cfg_data,
    output hlcfp_pkg::cfg_t           cfg
);

    logic [7:0] header_byte_reg;
    logic [7:0] header_byte_next;
    logic [7:0] command_limit_reg;
    logic [7:0] command_limit_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        header_byte_next   = header_byte_reg;
        command_limit_next = command_limit_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                hlcfp_pkg::CFG_HEADER_BYTE:   header_byte_next   = cfg_data;
                hlcfp_pkg::CFG_COMMAND_LIMIT: command_limit_next = cfg_data;
                default:                      header_byte_next   = header_byte_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_byte_reg   <= hlcfp_pkg::HEADER_BYTE_RESET;
            command_limit_reg <= hlcfp_pkg::COMMAND_LIMIT_RESET;
        end
        else
        begin
            header_byte_reg   <= header_byte_next;
            command_limit_reg <= command_limit_next;
        end
    end

    assign cfg.header_byte   = header_byte_reg;
    assign cfg.command_limit = command_limit_reg;

endmodule

// ----- rtl/hlcfp_parser.sv -----
module hlcfp_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    input  hlcfp_pkg::cfg_t    cfg,
    output hlcfp_pkg::result_t result
);

    hlcfp_pkg::parse_state_t state_reg;
    hlcfp_pkg::parse_state_t state_next;
    logic [7:0] frame_length_reg;
    logic [7:0] frame_length_next;
    logic [7:0] current_command_reg;
    logic [7:0] current_command_next;
    logic [7:0] payload_count_reg;
    logic [7:0] payload_count_next;

    logic       header_hit;
    logic [7:0] need;
    logic [8:0] count_inc;

    assign header_hit = (rx_byte == cfg.header_byte);
    // payload bytes owed; a length of one still takes one byte
    assign need = (frame_length_reg >= hlcfp_pkg::SHORT_FRAME_LENGTH)
                ? (frame_length_reg - hlcfp_pkg::SHORT_FRAME_LENGTH) : 8'd0;
    assign count_inc = {1'b0, payload_count_reg} + 9'd1;

    always_comb
    begin
        state_next           = state_reg;
        frame_length_next    = frame_length_reg;
        current_command_next = current_command_reg;
        payload_count_next   = payload_count_reg;
        result               = '0;
        unique case (state_reg)
            hlcfp_pkg::ST_HEADER1:
            begin
                state_next = header_hit ? hlcfp_pkg::ST_HEADER2 : hlcfp_pkg::ST_HEADER1;
            end
            hlcfp_pkg::ST_HEADER2:
            begin
                state_next = header_hit ? hlcfp_pkg::ST_LENGTH : hlcfp_pkg::ST_HEADER1;
            end
            hlcfp_pkg::ST_LENGTH:
            begin
                frame_length_next = rx_byte;
                state_next = (rx_byte != 8'd0) ? hlcfp_pkg::ST_COMMAND : hlcfp_pkg::ST_HEADER1;
            end
            hlcfp_pkg::ST_COMMAND:
            begin
                current_command_next = rx_byte;
                payload_count_next   = 8'd0;
                // two-byte frame ends here whether or not the command is legal
                if (frame_length_reg == hlcfp_pkg::SHORT_FRAME_LENGTH)
                begin
                    state_next         = hlcfp_pkg::ST_HEADER1;
                    result.frame_done  = 1'b1;
                    result.command     = rx_byte;
                    result.data_length = frame_length_reg;
                end
                else
                begin
                    state_next = (rx_byte < cfg.command_limit)
                               ? hlcfp_pkg::ST_PAYLOAD : hlcfp_pkg::ST_HEADER1;
                end
            end
            hlcfp_pkg::ST_PAYLOAD:
            begin
                result.payload_valid = 1'b1;
                result.payload_byte  = rx_byte;
                result.payload_index = payload_count_reg;
                result.command       = current_command_reg;
                result.data_length   = frame_length_reg;
                payload_count_next   = count_inc[7:0];
                if (count_inc >= {1'b0, need})
                begin
                    result.frame_done = 1'b1;
                    state_next        = hlcfp_pkg::ST_HEADER1;
                end
            end
            default:
            begin
                state_next = hlcfp_pkg::ST_HEADER1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= hlcfp_pkg::ST_HEADER1;
            frame_length_reg    <= 8'd0;
            current_command_reg <= 8'd0;
            payload_count_reg   <= 8'd0;
        end
        else if (step)
        begin
            state_reg           <= state_next;
            frame_length_reg    <= frame_length_next;
            current_command_reg <= current_command_next;
            payload_count_reg   <= payload_count_next;
        end
    end

endmodule

// ----- rtl/hlcfp_checker.sv -----
`include "header_length_command_frame_parser_core_macros.svh"

module hlcfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_stall,
    input logic [7:0]  rx_byte,
    input logic        result_valid,
    input logic        result_stall,
    input logic        payload_valid,
    input logic [7:0]  payload_byte,
    input logic [7:0]  payload_index,
    input logic        frame_done,
    input logic [7:0]  command,
    input logic [7:0]  data_length,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [0:0]  cfg_index,
    input logic [7:0]  cfg_data
);

    // a stalled result holds
    `HLCFP_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable({payload_valid, payload_byte, payload_index, frame_done, command, data_length}))

    // non-payload results carry zero byte and index
    `HLCFP_ASSERT_NOW(a_no_payload_zero, result_valid && !payload_valid, payload_byte == 8'd0 && payload_index == 8'd0)

    // results with no flags carry no frame info
    `HLCFP_ASSERT_NOW(a_idle_zero, result_valid && !payload_valid && !frame_done, command == 8'd0 && data_length == 8'd0)

    // last payload byte sits at length minus three
    `HLCFP_ASSERT_NOW(a_last_index, result_valid && payload_valid && frame_done && data_length >= 8'd3, payload_index == data_length - 8'd3)

endmodule

bind header_length_command_frame_parser_core hlcfp_checker u_hlcfp_checker (.*);
